// ----- sv/media_type_header_parser_unit_macros.svh -----
// Assertion macros shared by the media type header parser RTL.
// Included by every module that carries concurrent checks; no other dependencies.
`ifndef MEDIA_TYPE_HEADER_PARSER_UNIT_MACROS_SVH
`define MEDIA_TYPE_HEADER_PARSER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define MTHP_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Implication checked in the cycle after its trigger.
`define MTHP_ASSERT_NEXT(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) else $error(msg);
`else
`define MTHP_ASSERT(lbl, expr, msg)
`define MTHP_ASSERT_NEXT(lbl, trig, expr, msg)
`endif
`endif

// ----- sv/mthp_pkg.sv -----
// Types, character constants and byte classification functions of the media type parser.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mthp_pkg;

  // Characters the grammar refers to.
  localparam logic [7:0] CH_HTAB   = 8'd9;
  localparam logic [7:0] CH_SP     = 8'd32;
  localparam logic [7:0] CH_BANG   = 8'd33;
  localparam logic [7:0] CH_DQUOTE = 8'd34;
  localparam logic [7:0] CH_HASH   = 8'd35;
  localparam logic [7:0] CH_SLASH  = 8'd47;
  localparam logic [7:0] CH_SEMI   = 8'd59;
  localparam logic [7:0] CH_EQ     = 8'd61;
  localparam logic [7:0] CH_LBRACK = 8'd91;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_RBRACK = 8'd93;
  localparam logic [7:0] CH_TILDE  = 8'd126;
  localparam logic [7:0] CH_DEL    = 8'd127;

  // Field kinds reported with content characters.
  localparam logic [1:0] KIND_TYPE    = 2'd0;
  localparam logic [1:0] KIND_SUBTYPE = 2'd1;
  localparam logic [1:0] KIND_NAME    = 2'd2;
  localparam logic [1:0] KIND_VALUE   = 2'd3;

  // Width of the reported parameter number.
  localparam int PARAM_OUT_BITS = 8;

  // Parser phases, one-hot.
  typedef enum logic [9:0] {
    PH_TYPE        = 10'b00_0000_0001,
    PH_SUBTYPE     = 10'b00_0000_0010,
    PH_PRE_SEMI    = 10'b00_0000_0100,
    PH_NAME        = 10'b00_0000_1000,
    PH_VAL_START   = 10'b00_0001_0000,
    PH_VAL_TOKEN   = 10'b00_0010_0000,
    PH_QUOTED      = 10'b00_0100_0000,
    PH_ESCAPE      = 10'b00_1000_0000,
    PH_AFTER_QUOTE = 10'b01_0000_0000,
    PH_ERROR       = 10'b10_0000_0000
  } mthp_phase_t;

  // A classified byte as it travels from the front end to the parser.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       tok;
    logic       qd;
    logic       pair;
    logic       ows;
    logic       slash;
    logic       semi;
    logic       eq;
    logic       dquote;
    logic       bslash;
  } mthp_class_t;

  // Head of the byte queue as seen by the parser.
  typedef struct packed {
    logic        valid;
    mthp_class_t item;
  } mthp_head_t;

  function automatic logic is_token_char(input logic [7:0] c);
    logic alnum;
    logic punct;
    alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
            (c >= 8'h41 && c <= 8'h5A);
    punct = (c == 8'h21) || (c == 8'h23) || (c == 8'h24) || (c == 8'h25) ||
            (c == 8'h26) || (c == 8'h27) || (c == 8'h2A) || (c == 8'h2B) ||
            (c == 8'h2D) || (c == 8'h2E) || (c == 8'h5E) || (c == 8'h5F) ||
            (c == 8'h60) || (c == 8'h7C) || (c == 8'h7E);
    return alnum || punct;
  endfunction

  function automatic logic is_qdtext(input logic [7:0] c);
    return (c == CH_HTAB) || (c == CH_SP) || (c == CH_BANG) ||
           (c >= CH_HASH && c <= CH_LBRACK) || (c >= CH_RBRACK && c <= CH_TILDE) ||
           (c > CH_DEL);
  endfunction

  function automatic logic is_pair_char(input logic [7:0] c);
    return (c == CH_HTAB) || (c == CH_SP) || (c >= CH_BANG && c <= CH_TILDE) ||
           (c > CH_DEL);
  endfunction

endpackage

`default_nettype wire

// ----- sv/mthp_in_if.sv -----
// Input channel of the media type parser: one header byte per beat.
// Stand-alone interface; no dependencies.
`default_nettype none

interface mthp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, in_byte, last_byte, input ready);
  modport sink (input valid, in_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/mthp_out_if.sv -----
// Result channel of the media type parser: one parse result per beat.
// Stand-alone interface; no dependencies.
`default_nettype none

interface mthp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       char_valid;
  logic [1:0] field_kind;
  logic [7:0] param_number;
  logic       value_end;
  logic       accepted;
  logic       parse_error;

  modport source (output valid, char_out, char_valid, field_kind, param_number,
                  value_end, accepted, parse_error, input ready);
  modport sink (input valid, char_out, char_valid, field_kind, param_number,
                value_end, accepted, parse_error, output ready);
endinterface

`default_nettype wire

// ----- sv/mthp_front.sv -----
// Front end: accepts header bytes and classifies them for the parser.
// Depends on mthp_pkg and mthp_in_if.
`default_nettype none

module mthp_front
  import mthp_pkg::*;
(
  mthp_in_if.sink     in_ch,
  input  wire logic   q_full,
  output mthp_class_t push_item,
  output logic        push
);

  // A beat is taken whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // Classify the byte once so the parser only looks at flags.
  always_comb begin
    push_item.ch     = in_ch.in_byte;
    push_item.last   = in_ch.last_byte;
    push_item.tok    = is_token_char(in_ch.in_byte);
    push_item.qd     = is_qdtext(in_ch.in_byte);
    push_item.pair   = is_pair_char(in_ch.in_byte);
    push_item.ows    = (in_ch.in_byte == CH_SP) || (in_ch.in_byte == CH_HTAB);
    push_item.slash  = (in_ch.in_byte == CH_SLASH);
    push_item.semi   = (in_ch.in_byte == CH_SEMI);
    push_item.eq     = (in_ch.in_byte == CH_EQ);
    push_item.dquote = (in_ch.in_byte == CH_DQUOTE);
    push_item.bslash = (in_ch.in_byte == CH_BSLASH);
  end

endmodule

`default_nettype wire

// ----- sv/mthp_queue.sv -----
// Two-entry queue of classified bytes between the front end and the parser.
// Depends on mthp_pkg and the assertion macros header.
`default_nettype none
`include "media_type_header_parser_unit_macros.svh"

module mthp_queue
  import mthp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  mthp_class_t      push_item,
  input  wire logic        pop,
  output logic             q_full,
  output mthp_head_t       head
);

  mthp_class_t entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign q_full     = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.item  = entries[rd_ptr];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `MTHP_ASSERT(a_no_pop_empty, !(pop && count == 2'd0), "pop from empty byte queue")
  `MTHP_ASSERT(a_no_push_full, !(push && count == 2'd2), "push into full byte queue")
  `MTHP_ASSERT(a_count_range, count != 2'd3, "byte queue count out of range")

endmodule

`default_nettype wire

// ----- sv/mthp_back.sv -----
// Back end: grammar state machine and registered result stage.
// Depends on mthp_pkg, mthp_out_if and the assertion macros header.
`default_nettype none
`include "media_type_header_parser_unit_macros.svh"

module mthp_back
  import mthp_pkg::*;
#(
  parameter int PARAM_COUNT_BITS = 8
)(
  input  wire logic   clk,
  input  wire logic   rst,
  input  mthp_head_t  head,
  output logic        pop,
  mthp_out_if.source  out_ch
);

  localparam int SHOW_BITS = (PARAM_COUNT_BITS > PARAM_OUT_BITS) ?
                             PARAM_COUNT_BITS : PARAM_OUT_BITS;
  localparam logic [PARAM_COUNT_BITS-1:0] CNT_MAX = '1;

  mthp_phase_t                 phase;
  mthp_phase_t                 phase_next;
  logic                        tok_seen;
  logic                        tok_seen_next;
  logic [PARAM_COUNT_BITS-1:0] cnt;
  logic [PARAM_COUNT_BITS-1:0] cnt_next;
  logic [SHOW_BITS-1:0]        cnt_wide;

  logic                        out_valid;
  logic [7:0]                  char_out;
  logic                        char_valid;
  logic [1:0]                  field_kind;
  logic [7:0]                  param_number;
  logic                        value_end;
  logic                        accepted;
  logic                        parse_error;

  logic                        valid_c;
  logic [1:0]                  kind_c;
  logic                        acc_c;
  logic                        err_c;
  logic                        count_c;
  mthp_class_t                 b;

  assign b   = head.item;
  // The result register frees up in the same cycle it is taken.
  assign pop = head.valid && (!out_valid || out_ch.ready);

  // Grammar step for the byte at the queue head.
  always_comb begin
    phase_next    = phase;
    tok_seen_next = tok_seen;
    valid_c       = 1'b0;
    kind_c        = KIND_TYPE;
    count_c       = 1'b0;
    unique case (phase)
      PH_TYPE: begin
        priority if (b.tok) begin
          valid_c = 1'b1; kind_c = KIND_TYPE; tok_seen_next = 1'b1;
        end else if (b.slash && tok_seen) begin
          phase_next = PH_SUBTYPE; tok_seen_next = 1'b0;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_SUBTYPE: begin
        priority if (b.tok) begin
          valid_c = 1'b1; kind_c = KIND_SUBTYPE; tok_seen_next = 1'b1;
        end else if (!tok_seen) begin
          phase_next = PH_ERROR;
        end else if (b.ows) begin
          phase_next = PH_PRE_SEMI;
        end else if (b.semi) begin
          count_c = 1'b1; phase_next = PH_NAME; tok_seen_next = 1'b0;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_PRE_SEMI: begin
        priority if (b.ows) begin
          phase_next = PH_PRE_SEMI;
        end else if (b.semi) begin
          count_c = 1'b1; phase_next = PH_NAME; tok_seen_next = 1'b0;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_NAME: begin
        priority if (b.tok) begin
          valid_c = 1'b1; kind_c = KIND_NAME; tok_seen_next = 1'b1;
        end else if (b.eq) begin
          phase_next = PH_VAL_START; tok_seen_next = 1'b0;
        end else if (b.ows && !tok_seen) begin
          phase_next = PH_NAME;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_VAL_START: begin
        priority if (b.dquote) begin
          phase_next = PH_QUOTED;
        end else if (b.tok) begin
          valid_c = 1'b1; kind_c = KIND_VALUE; tok_seen_next = 1'b1;
          phase_next = PH_VAL_TOKEN;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_VAL_TOKEN, PH_AFTER_QUOTE: begin
        priority if (phase == PH_VAL_TOKEN && b.tok) begin
          valid_c = 1'b1; kind_c = KIND_VALUE;
        end else if (b.ows) begin
          phase_next = PH_PRE_SEMI;
        end else if (b.semi) begin
          count_c = 1'b1; phase_next = PH_NAME; tok_seen_next = 1'b0;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_QUOTED: begin
        priority if (b.qd) begin
          valid_c = 1'b1; kind_c = KIND_VALUE;
        end else if (b.bslash) begin
          phase_next = PH_ESCAPE;
        end else if (b.dquote) begin
          phase_next = PH_AFTER_QUOTE;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_ESCAPE: begin
        priority if (b.pair) begin
          valid_c = 1'b1; kind_c = KIND_VALUE; phase_next = PH_QUOTED;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_ERROR: begin
        phase_next = PH_ERROR;
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase

    // Saturating separator count.
    cnt_next = (count_c && cnt != CNT_MAX) ? cnt + PARAM_COUNT_BITS'(1) : cnt;

    err_c = (phase_next == PH_ERROR);
    if (err_c) begin
      valid_c = 1'b0;
    end
    acc_c = 1'b0;
    if (b.last) begin
      acc_c = (phase_next == PH_SUBTYPE && tok_seen_next) ||
              (phase_next == PH_VAL_TOKEN) || (phase_next == PH_AFTER_QUOTE);
      if (!acc_c) begin
        err_c = 1'b1;
      end
    end
  end

  // Reported count is clipped to the field width.
  assign cnt_wide = SHOW_BITS'(cnt_next);

  // Parser state; the last byte returns it to the start of a new value.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_TYPE;
      tok_seen <= 1'b0;
      cnt      <= '0;
    end else if (pop) begin
      if (b.last) begin
        phase    <= PH_TYPE;
        tok_seen <= 1'b0;
        cnt      <= '0;
      end else begin
        phase    <= phase_next;
        tok_seen <= tok_seen_next;
        cnt      <= cnt_next;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      char_out     <= valid_c ? b.ch : 8'd0;
      char_valid   <= valid_c;
      field_kind   <= valid_c ? kind_c : KIND_TYPE;
      param_number <= (cnt_wide > SHOW_BITS'(255)) ? 8'hFF : cnt_wide[7:0];
      value_end    <= b.last;
      accepted     <= acc_c;
      parse_error  <= err_c;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.char_out     = char_out;
  assign out_ch.char_valid   = char_valid;
  assign out_ch.field_kind   = field_kind;
  assign out_ch.param_number = param_number;
  assign out_ch.value_end    = value_end;
  assign out_ch.accepted     = accepted;
  assign out_ch.parse_error  = parse_error;

  // A content byte may carry the error flag only as the unfinished last byte of a value.
  `MTHP_ASSERT_NEXT(a_last_restarts, pop && b.last, phase == PH_TYPE && cnt == '0 && !tok_seen, "parser did not restart after last byte")
  `MTHP_ASSERT(a_acc_on_end, !(out_valid && accepted && (!value_end || parse_error)), "accept without clean end of value")
  `MTHP_ASSERT(a_no_char_in_error, !(out_valid && char_valid && parse_error && !value_end), "content character reported with error")

endmodule

`default_nettype wire

// ----- sv/media_type_header_parser_unit.sv -----
// Top level of the media type header parser: front end, byte queue and parser.
// Depends on mthp_pkg, mthp_in_if, mthp_out_if, mthp_front, mthp_queue, mthp_back.
//
//   channel  | dir | beat contents
//   ---------+-----+---------------------------------------------------------
//   in_ch    | in  | in_byte, last_byte
//   out_ch   | out | char_out, char_valid, field_kind, param_number,
//            |     | value_end, accepted, parse_error
//
// One byte per cycle sustained while out_ch takes results; each byte gives one result beat.
// An accepted byte passes through the two-entry byte queue and then the result
// register on its way to out_ch.
// The parser state machine steps once per byte and sets the rate.
// Reset is synchronous; no clearing pass.
// A stall on out_ch fills the queue; in_ch.ready drops only when it is full.
`default_nettype none

module media_type_header_parser_unit
  import mthp_pkg::*;
#(
  parameter int PARAM_COUNT_BITS = 8
)(
  input  wire logic   clk,
  input  wire logic   rst,
  mthp_in_if.sink     in_ch,
  mthp_out_if.source  out_ch
);

  mthp_class_t push_item;
  logic        push;
  logic        pop;
  logic        q_full;
  mthp_head_t  head;

  mthp_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push_item (push_item),
    .push      (push)
  );

  mthp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_full    (q_full),
    .head      (head)
  );

  mthp_back #(
    .PARAM_COUNT_BITS (PARAM_COUNT_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
